// ----- hw/rtl/gcev_pkg.sv -----
// shared types, constants and level helpers for the gamepad change event generator
`timescale 1ns / 1ps
`default_nettype none

package gcev_pkg;

  // slot layout of one report: buttons, then triggers, then one slot per stick axis
  localparam int NUM_BUTTONS  = 14;
  localparam int NUM_TRIGGERS = 2;
  localparam int NUM_AXES     = 4;
  localparam int NUM_SLOTS    = NUM_BUTTONS + NUM_TRIGGERS + NUM_AXES;
  localparam int SLOT_W       = $clog2(NUM_SLOTS);

  localparam logic [15:0] LEVEL_FULL      = 16'h8000;
  localparam logic [4:0]  ID_TRIGGER_BASE = 5'd14;
  localparam logic [4:0]  ID_STICK_BASE   = 5'd16;
  localparam logic [4:0]  ID_MAX          = 5'd23;

  // register reset values
  localparam logic [7:0]  THRESHOLD_RESET = 8'd30;
  localparam logic [14:0] DEADZONE_RESET  = 15'd8689;

  // register index codes, taken from the word address
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_DEADZONE  = 1'b1;

  typedef struct packed {
    logic [7:0]  trigger_threshold;
    logic [14:0] stick_deadzone;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  control_id;
    logic        pressed;
    logic [15:0] level;
  } slot_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]        mask;
    slot_t [NUM_SLOTS-1:0]       slots;
  } event_set_t;

  // bit of the button word behind each button control (bits 10 and 11 unused)
  function automatic logic [3:0] button_bit(input logic [3:0] idx);
    logic [3:0] b;
    if (idx < 4'd10) begin
      b = idx;
    end else begin
      b = idx + 4'd2;
    end
    return b;
  endfunction

  // floor(t * 32768 / 255) = t*128 + floor(t*128 / 255), the division by 255
  // done as (x + (x >> 8) + 1) >> 8, exact over this range
  function automatic logic [15:0] trigger_level(input logic [7:0] t);
    logic [14:0] x;
    logic [15:0] s;
    x = {t, 7'b0};
    s = {1'b0, x} + {9'b0, x[14:8]} + 16'd1;
    return {1'b0, x} + {8'b0, s[15:8]};
  endfunction

  // floor(v * 32768 / 32767) for 0 < v < 32768 is v, plus one at full scale
  function automatic logic [15:0] axis_level_pos(input logic [14:0] v);
    return {1'b0, v} + {15'b0, (v == 15'h7FFF)};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gcev_ifs.sv -----
// report and change event channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface gcev_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        packet_number;
  logic [15:0]        buttons;
  logic [7:0]         trig_left;
  logic [7:0]         trig_right;
  logic signed [15:0] left_x;
  logic signed [15:0] left_y;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;

  modport source (
    output valid, packet_number, buttons, trig_left, trig_right,
    output left_x, left_y, right_x, right_y,
    input  ready
  );
  modport sink (
    input  valid, packet_number, buttons, trig_left, trig_right,
    input  left_x, left_y, right_x, right_y,
    output ready
  );
endinterface

interface gcev_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  control_id;
  logic        pressed;
  logic [15:0] level;
  logic        last;

  modport source (output valid, control_id, pressed, level, last, input ready);
  modport sink (input valid, control_id, pressed, level, last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gcev_cfg_regs.sv -----
// apb configuration registers: trigger threshold and stick deadzone
`timescale 1ns / 1ps
`default_nettype none

module gcev_cfg_regs
  import gcev_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // register write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_threshold <= THRESHOLD_RESET;
      cfg.stick_deadzone    <= DEADZONE_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_THRESHOLD: cfg.trigger_threshold <= pwdata[7:0];
        REG_DEADZONE:  cfg.stick_deadzone    <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = {24'b0, cfg.trigger_threshold};
      REG_DEADZONE:  prdata = {17'b0, cfg.stick_deadzone};
      default:       prdata = 32'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gcev_detect.sv -----
// report input register, stored previous report and change detection
`timescale 1ns / 1ps
`default_nettype none

module gcev_detect
  import gcev_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  gcev_in_if.sink   report,
  output logic      set_valid,
  input  wire logic set_ready,
  output event_set_t set
);

  logic [31:0]        in_packet;
  logic [15:0]        in_buttons;
  logic [7:0]         in_trig [NUM_TRIGGERS];
  logic signed [15:0] in_axis [NUM_AXES];

  logic [31:0]        prev_packet;
  logic [15:0]        prev_buttons;
  logic [7:0]         prev_trig [NUM_TRIGGERS];
  logic signed [15:0] prev_axis [NUM_AXES];

  logic stale;
  logic advance;

  assign advance      = set_valid && set_ready;
  assign report.ready = !set_valid || set_ready;
  assign stale        = !(in_packet > prev_packet);

  // input register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      set_valid <= 1'b0;
    end else if (report.valid && report.ready) begin
      set_valid <= 1'b1;
    end else if (advance) begin
      set_valid <= 1'b0;
    end
  end

  // input payload
  always_ff @(posedge clk) begin
    if (report.valid && report.ready) begin
      in_packet   <= report.packet_number;
      in_buttons  <= report.buttons;
      in_trig[0]  <= report.trig_left;
      in_trig[1]  <= report.trig_right;
      in_axis[0]  <= report.left_x;
      in_axis[1]  <= report.left_y;
      in_axis[2]  <= report.right_x;
      in_axis[3]  <= report.right_y;
    end
  end

  // previous report, replaced when a fresh report moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_packet  <= 32'b0;
      prev_buttons <= 16'b0;
      for (int i = 0; i < NUM_TRIGGERS; i++) begin
        prev_trig[i] <= 8'b0;
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        prev_axis[i] <= 16'sb0;
      end
    end else if (advance && !stale) begin
      prev_packet  <= in_packet;
      prev_buttons <= in_buttons;
      for (int i = 0; i < NUM_TRIGGERS; i++) begin
        prev_trig[i] <= in_trig[i];
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        prev_axis[i] <= in_axis[i];
      end
    end
  end

  // per-control change flags, pressed state and level
  always_comb begin
    logic [3:0]           b;
    logic [4:0]           pos_id;
    logic [15:0]          mag;
    logic [NUM_SLOTS-1:0] changed;
    int                   s;
    changed = '0;
    set.slots = '0;

    // buttons
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      b = button_bit(4'(i));
      changed[i] = in_buttons[b] ^ prev_buttons[b];
      set.slots[i].control_id = 5'(i);
      set.slots[i].pressed    = in_buttons[b];
      set.slots[i].level      = in_buttons[b] ? LEVEL_FULL : 16'b0;
    end

    // triggers
    for (int i = 0; i < NUM_TRIGGERS; i++) begin
      s = NUM_BUTTONS + i;
      changed[s] = (in_trig[i] != prev_trig[i]);
      set.slots[s].control_id = ID_TRIGGER_BASE + 5'(i);
      set.slots[s].pressed    = (in_trig[i] > cfg.trigger_threshold);
      set.slots[s].level      = trigger_level(in_trig[i]);
    end

    // stick axes: negative direction id is one below the positive one
    for (int i = 0; i < NUM_AXES; i++) begin
      s = NUM_BUTTONS + NUM_TRIGGERS + i;
      pos_id = ID_STICK_BASE + 5'(4 * (i / 2) + 2 * (i % 2) + 1);
      mag = 16'(~in_axis[i]) + 16'd1;
      changed[s] = (in_axis[i] != prev_axis[i]);
      if (in_axis[i] > 16'sd0) begin
        set.slots[s].control_id = pos_id;
        set.slots[s].pressed    = ({1'b0, in_axis[i][14:0]} > {1'b0, cfg.stick_deadzone});
        set.slots[s].level      = axis_level_pos(in_axis[i][14:0]);
      end else if (in_axis[i] < 16'sd0) begin
        set.slots[s].control_id = pos_id - 5'd1;
        set.slots[s].pressed    = (mag > {1'b0, cfg.stick_deadzone});
        set.slots[s].level      = mag;
      end else begin
        // back at centre: release the side it came from
        set.slots[s].control_id = (prev_axis[i] > 16'sd0) ? pos_id : pos_id - 5'd1;
        set.slots[s].pressed    = 1'b0;
        set.slots[s].level      = 16'b0;
      end
    end

    set.mask = stale ? '0 : changed;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gcev_emit.sv -----
// event set register and output register, one change event per transfer
`timescale 1ns / 1ps
`default_nettype none

module gcev_emit
  import gcev_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       set_valid,
  output logic            set_ready,
  input  wire event_set_t set,
  gcev_out_if.source      change
);

  logic [NUM_SLOTS-1:0] mask;
  logic [NUM_SLOTS-1:0] mask_next;
  logic [NUM_SLOTS-1:0] rest;
  slot_t                slots [NUM_SLOTS];
  logic [SLOT_W-1:0]    sel;
  logic                 load;

  // pick the lowest pending slot
  always_comb begin
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = SLOT_W'(i);
      end
    end
  end

  assign rest      = mask & (mask - NUM_SLOTS'(1));
  assign load      = (mask != '0) && (!change.valid || change.ready);
  assign set_ready = (mask == '0) || (load && (rest == '0));

  always_comb begin
    if (set_valid && set_ready) begin
      mask_next = set.mask;
    end else if (load) begin
      mask_next = rest;
    end else begin
      mask_next = mask;
    end
  end

  // pending mask
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  // event slots of the report being sent
  always_ff @(posedge clk) begin
    if (set_valid && set_ready) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slots[i] <= set.slots[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      change.valid <= 1'b0;
    end else if (load) begin
      change.valid <= 1'b1;
    end else if (change.ready) begin
      change.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      change.control_id <= slots[sel].control_id;
      change.pressed    <= slots[sel].pressed;
      change.level      <= slots[sel].level;
      change.last       <= (rest == '0);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gamepad_change_event_generator.sv -----
// gamepad change event generator top level
// path: report input register, then event set register, then output register for each event
// throughput: one event per cycle while the receiver is ready; a report with n changed
//   controls (at most 20) gives n events, a report with none passes on with no event
// the next report is taken in the cycle the last event of the one before is loaded
// reset: stored report cleared to zero, threshold 30, deadzone 8689, no events pending
`timescale 1ns / 1ps
`default_nettype none

module gamepad_change_event_generator
  import gcev_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  gcev_in_if.sink          report,
  gcev_out_if.source       change
);

  cfg_t       cfg;
  event_set_t set;
  logic       set_valid;
  logic       set_ready;

  // configuration registers
  gcev_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // change detection against the stored report
  gcev_detect u_detect (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .report    (report),
    .set_valid (set_valid),
    .set_ready (set_ready),
    .set       (set)
  );

  // event sequencing
  gcev_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .set_valid (set_valid),
    .set_ready (set_ready),
    .set       (set),
    .change    (change)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/gcev_checker.sv -----
// port level checks on the change event channel, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module gcev_checker
  import gcev_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [4:0]  control_id,
  input wire logic        pressed,
  input wire logic [15:0] level,
  input wire logic        last
);

  // no event straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("event valid after reset");

  // a stalled event holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(control_id) && $stable(pressed)
      && $stable(level) && $stable(last))
    else $error("stalled event changed");

  // control ids stay in range and levels never exceed full scale
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> control_id <= ID_MAX && level <= LEVEL_FULL)
    else $error("control id or level out of range");

  // buttons report exactly full or zero, matching pressed
  a_button_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && control_id < ID_TRIGGER_BASE |->
      (pressed && level == LEVEL_FULL) || (!pressed && level == 16'b0))
    else $error("button level does not match pressed");

  // a released stick direction at zero level cannot be pressed
  a_stick_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && control_id >= ID_STICK_BASE && level == 16'b0 |-> !pressed)
    else $error("stick direction pressed at zero level");

endmodule

bind gamepad_change_event_generator gcev_checker u_gcev_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (change.valid),
  .out_ready  (change.ready),
  .control_id (change.control_id),
  .pressed    (change.pressed),
  .level      (change.level),
  .last       (change.last)
);

`default_nettype wire

// ----- tb/tb_gamepad_change_event_generator.sv -----
// self-checking testbench for the gamepad change event generator
`timescale 1ns / 1ps

module tb_gamepad_change_event_generator;
  import gcev_pkg::*;

  localparam int PHASES         = 6;
  localparam int PHASE_REPORTS  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 10;
  localparam int MAX_CHANGES    = NUM_SLOTS;

  // control ids used by the directed rows
  localparam logic [4:0] CTL_DPAD_UP       = 5'd0;
  localparam logic [4:0] CTL_LEFT_TRIGGER  = ID_TRIGGER_BASE;
  localparam logic [4:0] CTL_LX_NEG        = ID_STICK_BASE;
  localparam logic [4:0] CTL_LX_POS        = ID_STICK_BASE + 5'd1;
  localparam logic [4:0] CTL_RY_NEG        = ID_STICK_BASE + 5'd6;

  typedef struct packed {
    logic [31:0] packet_number;
    logic [15:0] buttons;
    logic [7:0]  trig_left;
    logic [7:0]  trig_right;
    logic [15:0] left_x;
    logic [15:0] left_y;
    logic [15:0] right_x;
    logic [15:0] right_y;
  } report_t;

  typedef struct packed {
    logic [4:0]  control_id;
    logic        pressed;
    logic [15:0] level;
    logic        last;
  } change_t;

  // how a directed row gets its expectation
  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_NONE,
    EXP_ONE
  } exp_kind_t;

  typedef struct packed {
    report_t   rep;
    exp_kind_t kind;
    change_t   ev;
  } row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gcev_in_if  rpt_if ();
  gcev_out_if evt_if ();

  gamepad_change_event_generator u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .report  (rpt_if),
    .change  (evt_if)
  );

  // shadow of the block: registers and stored report
  logic [7:0]  cfg_threshold;
  logic [14:0] cfg_deadzone;
  logic [31:0] seen_packet;
  logic [15:0] seen_buttons;
  logic [7:0]  seen_trig [2];
  logic [15:0] seen_axis [4];

  change_t new_changes [MAX_CHANGES];
  int      new_count;
  change_t pending_changes [$];
  row_t    dir_rows [$];

  int errors;
  int reports_sent;
  int stale_sent;
  int changes_checked;
  int settings_used;
  int idle_cycles;
  int hold_requests;
  int hold_served;
  int hold_left;
  int stall_left;
  bit quiet;
  bit src_calm;
  bit sink_calm;

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // change list that one report causes, updating the shadow state
  function automatic void add_change(input logic [4:0] id, input logic p,
                                     input logic [15:0] lvl);
    new_changes[new_count] = '{control_id: id, pressed: p, level: lvl, last: 1'b0};
    new_count++;
  endfunction

  function automatic void derive_changes(input report_t r);
    int                 idx;
    int                 bitpos;
    int                 v;
    int                 old;
    int                 mag;
    logic signed [15:0] sv;
    logic [4:0]         neg_id;
    logic [4:0]         pos_id;
    logic [7:0]         trig_now [2];
    logic [15:0]        axis_now [4];
    new_count = 0;
    if (r.packet_number <= seen_packet) return;
    trig_now[0] = r.trig_left;
    trig_now[1] = r.trig_right;
    axis_now[0] = r.left_x;
    axis_now[1] = r.left_y;
    axis_now[2] = r.right_x;
    axis_now[3] = r.right_y;
    // buttons, skipping the two unused bits
    for (idx = 0; idx < NUM_BUTTONS; idx++) begin
      bitpos = (idx < 10) ? idx : idx + 2;
      if (r.buttons[bitpos] != seen_buttons[bitpos]) begin
        add_change(idx[4:0], r.buttons[bitpos], r.buttons[bitpos] ? LEVEL_FULL : 16'd0);
      end
    end
    // triggers against the threshold
    for (idx = 0; idx < NUM_TRIGGERS; idx++) begin
      if (trig_now[idx] != seen_trig[idx]) begin
        v = (int'(trig_now[idx]) * 32768) / 255;
        add_change(ID_TRIGGER_BASE + idx[4:0], trig_now[idx] > cfg_threshold, v[15:0]);
      end
    end
    // stick axes split into two directions each
    for (idx = 0; idx < NUM_AXES; idx++) begin
      neg_id = ID_STICK_BASE + 5'(4 * (idx >> 1) + 2 * (idx & 1));
      pos_id = neg_id + 5'd1;
      sv = axis_now[idx];
      v = sv;
      sv = seen_axis[idx];
      old = sv;
      if (v != old) begin
        if (v > 0) begin
          mag = (v * 32768) / 32767;
          add_change(pos_id, v > int'(cfg_deadzone), mag[15:0]);
        end else if (v < 0) begin
          mag = -v;
          add_change(neg_id, mag > int'(cfg_deadzone), mag[15:0]);
        end else if (old > 0) begin
          add_change(pos_id, 1'b0, 16'd0);
        end else begin
          add_change(neg_id, 1'b0, 16'd0);
        end
      end
    end
    seen_packet  = r.packet_number;
    seen_buttons = r.buttons;
    for (idx = 0; idx < NUM_TRIGGERS; idx++) seen_trig[idx] = trig_now[idx];
    for (idx = 0; idx < NUM_AXES; idx++) seen_axis[idx] = axis_now[idx];
    if (new_count > 0) new_changes[new_count - 1].last = 1'b1;
  endfunction

  function automatic report_t mk_report(input logic [31:0] pkt, input logic [15:0] btn,
                                        input logic [7:0] lt, input logic [7:0] rt,
                                        input logic [15:0] lx, input logic [15:0] ly,
                                        input logic [15:0] rx, input logic [15:0] ry);
    report_t r;
    r.packet_number = pkt;
    r.buttons       = btn;
    r.trig_left     = lt;
    r.trig_right    = rt;
    r.left_x        = lx;
    r.left_y        = ly;
    r.right_x       = rx;
    r.right_y       = ry;
    return r;
  endfunction

  function automatic void add_row(input report_t r, input exp_kind_t k, input change_t e);
    row_t row;
    row.rep  = r;
    row.kind = k;
    row.ev   = e;
    dir_rows.push_back(row);
  endfunction

  // random stimulus helpers
  function automatic logic [15:0] pick_axis(input logic [15:0] old, input logic [14:0] dz);
    logic signed [15:0] so;
    int                 v;
    int                 d;
    so = old;
    d  = dz;
    case ($urandom_range(0, 9))
      0: v = so;
      1: v = 0;
      2: v = 32767;
      3: v = -32768;
      4: v = d;
      5: v = (d == 32767) ? d : d + 1;
      6: v = -d;
      7: v = -d - 1;
      8: begin
        if (so < 0) begin
          v = -int'($urandom_range(1, 32768));
        end else begin
          v = $urandom_range(1, 32767);
        end
      end
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [7:0] pick_trigger(input logic [7:0] old, input logic [7:0] thr);
    logic [7:0] t;
    case ($urandom_range(0, 6))
      0: t = old;
      1: t = thr;
      2: t = thr + 8'd1;
      3: t = 8'd0;
      4: t = 8'd255;
      default: t = $urandom_range(0, 255);
    endcase
    return t;
  endfunction

  function automatic report_t gen_report();
    report_t r;
    int      kind;
    r = mk_report(seen_packet, seen_buttons, seen_trig[0], seen_trig[1],
                  seen_axis[0], seen_axis[1], seen_axis[2], seen_axis[3]);
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // stale report with random content
      r = {$urandom(), $urandom(), $urandom(), $urandom()};
      r.packet_number = (seen_packet == 0) ? 32'd0 : $urandom_range(seen_packet, 0);
    end else if (kind < 20) begin
      // same controls, newer packet
      r.packet_number = seen_packet + 32'd1;
    end else begin
      if (seen_packet < 32'h7000_0000 && $urandom_range(0, 19) == 0) begin
        r.packet_number = seen_packet + $urandom_range(1, 32'h0010_0000);
      end else begin
        r.packet_number = seen_packet + $urandom_range(1, 4);
      end
      case ($urandom_range(0, 3))
        0: r.buttons = seen_buttons;
        1: r.buttons = seen_buttons ^ (16'h1 << $urandom_range(0, 15));
        2: r.buttons = $urandom();
        default: r.buttons = seen_buttons ^ (16'($urandom()) & 16'($urandom()));
      endcase
      r.trig_left  = pick_trigger(seen_trig[0], cfg_threshold);
      r.trig_right = pick_trigger(seen_trig[1], cfg_threshold);
      r.left_x  = pick_axis(seen_axis[0], cfg_deadzone);
      r.left_y  = pick_axis(seen_axis[1], cfg_deadzone);
      r.right_x = pick_axis(seen_axis[2], cfg_deadzone);
      r.right_y = pick_axis(seen_axis[3], cfg_deadzone);
    end
    return r;
  endfunction

  task automatic put_fields(input report_t r);
    rpt_if.packet_number <= r.packet_number;
    rpt_if.buttons       <= r.buttons;
    rpt_if.trig_left     <= r.trig_left;
    rpt_if.trig_right    <= r.trig_right;
    rpt_if.left_x        <= r.left_x;
    rpt_if.left_y        <= r.left_y;
    rpt_if.right_x       <= r.right_x;
    rpt_if.right_y       <= r.right_y;
  endtask

  // offer one report, then queue what it should cause once it is transferred
  task automatic send_report(input report_t r, input exp_kind_t k, input change_t e);
    int i;
    if (!quiet && !src_calm && $urandom_range(0, 5) == 0) begin
      rpt_if.valid <= 1'b0;
      put_fields({$urandom(), $urandom(), $urandom(), $urandom()});
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    put_fields(r);
    rpt_if.valid <= 1'b1;
    do @(posedge clk); while (!rpt_if.ready);
    reports_sent++;
    if (r.packet_number <= seen_packet) stale_sent++;
    derive_changes(r);
    case (k)
      EXP_NONE: ;
      EXP_ONE:  pending_changes.push_back(e);
      default: begin
        for (i = 0; i < new_count; i++) pending_changes.push_back(new_changes[i]);
      end
    endcase
  endtask

  // sender pause until every change event is back
  task automatic wait_drained(input int extra);
    rpt_if.valid <= 1'b0;
    do @(posedge clk); while (pending_changes.size() > 0);
    repeat (extra) @(posedge clk);
  endtask

  // optional register write followed by a read back
  task automatic reg_access(input logic idx, input bit do_write, input logic [31:0] value);
    logic [31:0] want;
    if (do_write) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (idx == REG_THRESHOLD) begin
        cfg_threshold = value[7:0];
      end else begin
        cfg_deadzone = value[14:0];
      end
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = (idx == REG_THRESHOLD) ? {24'b0, cfg_threshold} : {17'b0, cfg_deadzone};
    if (prdata !== want) begin
      errors++;
      $display("%0t: register %0d read back: expected %0h, got %0h",
               $time, idx, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] thr, input logic [14:0] dz);
    reg_access(REG_THRESHOLD, 1'b1, ($urandom() & 32'hFFFF_FF00) | {24'b0, thr});
    reg_access(REG_DEADZONE, 1'b1, ($urandom() & 32'hFFFF_8000) | {17'b0, dz});
    settings_used++;
  endtask

  // change event checker
  always @(posedge clk) begin
    change_t got;
    change_t want;
    if (!rst && evt_if.valid && evt_if.ready) begin
      got = '{control_id: evt_if.control_id, pressed: evt_if.pressed,
              level: evt_if.level, last: evt_if.last};
      if (pending_changes.size() == 0) begin
        errors++;
        $display({"%0t: unexpected change event: expected none, ",
                  "got id %0d pressed %0b level %0d last %0b"},
                 $time, got.control_id, got.pressed, got.level, got.last);
      end else begin
        want = pending_changes.pop_front();
        changes_checked++;
        if (got.control_id !== want.control_id || got.pressed !== want.pressed ||
            got.level !== want.level || got.last !== want.last) begin
          errors++;
          $display({"%0t: change event mismatch: ",
                    "expected id %0d pressed %0b level %0d last %0b, ",
                    "got id %0d pressed %0b level %0d last %0b"},
                   $time, want.control_id, want.pressed, want.level, want.last,
                   got.control_id, got.pressed, got.level, got.last);
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off on request, none at the end
  always @(posedge clk) begin
    if (rst) begin
      evt_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      evt_if.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      evt_if.ready <= 1'b0;
    end else if (quiet || sink_calm) begin
      evt_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      evt_if.ready <= 1'b0;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      evt_if.ready <= 1'b0;
    end else begin
      evt_if.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || psel || (rpt_if.valid && rpt_if.ready) || (evt_if.valid && evt_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d change events outstanding",
                 $time, idle_cycles, pending_changes.size());
        $display("tb_gamepad_change_event_generator failed");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    report_t     r;
    int          p;
    int          accepted;
    int          i;
    logic [7:0]  thr;
    logic [14:0] dz;
    errors = 0;
    reports_sent = 0;
    stale_sent = 0;
    changes_checked = 0;
    settings_used = 0;
    idle_cycles = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    stall_left = 0;
    quiet = 1'b0;
    src_calm = 1'b0;
    sink_calm = 1'b0;
    cfg_threshold = THRESHOLD_RESET;
    cfg_deadzone  = DEADZONE_RESET;
    seen_packet  = '0;
    seen_buttons = '0;
    for (i = 0; i < NUM_TRIGGERS; i++) seen_trig[i] = '0;
    for (i = 0; i < NUM_AXES; i++) seen_axis[i] = '0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rpt_if.valid = 1'b0;
    rpt_if.packet_number = '0;
    rpt_if.buttons = '0;
    rpt_if.trig_left = '0;
    rpt_if.trig_right = '0;
    rpt_if.left_x = '0;
    rpt_if.left_y = '0;
    rpt_if.right_x = '0;
    rpt_if.right_y = '0;
    evt_if.ready = 1'b0;

    // directed rows, at the reset register values
    add_row(mk_report(32'd1, 16'h0000, 8'd0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0), EXP_NONE, '0);
    add_row(mk_report(32'd1, 16'h0001, 8'd0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0), EXP_NONE, '0);
    add_row(mk_report(32'd0, 16'hFFFF, 8'd255, 8'd255, 16'h8000, 16'h8000, 16'h8000, 16'h8000),
            EXP_NONE, '0);
    add_row(mk_report(32'd2, 16'h0001, 8'd0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0), EXP_ONE,
            '{control_id: CTL_DPAD_UP, pressed: 1'b1, level: LEVEL_FULL, last: 1'b1});
    add_row(mk_report(32'd3, 16'h0C01, 8'd0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0), EXP_NONE, '0);
    add_row(mk_report(32'd4, 16'hFFFF, 8'd0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0), EXP_MODEL, '0);
    add_row(mk_report(32'd5, 16'h0000, 8'd0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0), EXP_MODEL, '0);
    add_row(mk_report(32'd6, 16'h0000, 8'd255, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0), EXP_ONE,
            '{control_id: CTL_LEFT_TRIGGER, pressed: 1'b1, level: LEVEL_FULL, last: 1'b1});
    add_row(mk_report(32'd7, 16'h0000, 8'd255, 8'd30, 16'h0, 16'h0, 16'h0, 16'h0), EXP_MODEL, '0);
    add_row(mk_report(32'd8, 16'h0000, 8'd0, 8'd31, 16'h0, 16'h0, 16'h0, 16'h0), EXP_MODEL, '0);
    add_row(mk_report(32'd9, 16'h0000, 8'd0, 8'd31, 16'h7FFF, 16'h0, 16'h0, 16'h0), EXP_ONE,
            '{control_id: CTL_LX_POS, pressed: 1'b1, level: LEVEL_FULL, last: 1'b1});
    add_row(mk_report(32'd10, 16'h0000, 8'd0, 8'd31, 16'h0, 16'h0, 16'h0, 16'h0), EXP_ONE,
            '{control_id: CTL_LX_POS, pressed: 1'b0, level: 16'd0, last: 1'b1});
    add_row(mk_report(32'd11, 16'h0000, 8'd0, 8'd31, 16'h8000, 16'h0, 16'h0, 16'h0), EXP_ONE,
            '{control_id: CTL_LX_NEG, pressed: 1'b1, level: LEVEL_FULL, last: 1'b1});
    add_row(mk_report(32'd12, 16'h0000, 8'd0, 8'd31, 16'h0, 16'h0, 16'h0, 16'h0), EXP_ONE,
            '{control_id: CTL_LX_NEG, pressed: 1'b0, level: 16'd0, last: 1'b1});
    add_row(mk_report(32'd13, 16'h0000, 8'd0, 8'd31, 16'h0, 16'sd8689, -16'sd8690, 16'h0),
            EXP_MODEL, '0);
    add_row(mk_report(32'd14, 16'h0000, 8'd0, 8'd31, 16'h0, 16'sd8690, -16'sd8689, 16'h0),
            EXP_MODEL, '0);
    add_row(mk_report(32'd15, 16'h0000, 8'd0, 8'd31, 16'h0, -16'sd100, -16'sd8689, 16'h7FFF),
            EXP_MODEL, '0);
    add_row(mk_report(32'd16, 16'h0000, 8'd0, 8'd31, 16'h0, -16'sd100, -16'sd8689, 16'h8000),
            EXP_ONE, '{control_id: CTL_RY_NEG, pressed: 1'b1, level: LEVEL_FULL, last: 1'b1});
    add_row(mk_report(32'd17, 16'hFFFF, 8'd255, 8'd255, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
            EXP_MODEL, '0);
    add_row(mk_report(32'd18, 16'h0000, 8'd0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0), EXP_MODEL, '0);
    add_row(mk_report(32'd19, 16'hA5A5, 8'd31, 8'd30, 16'sd1, -16'sd1, 16'sd32766, -16'sd32767),
            EXP_MODEL, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values of both registers
    reg_access(REG_THRESHOLD, 1'b0, '0);
    reg_access(REG_DEADZONE, 1'b0, '0);

    foreach (dir_rows[i]) send_report(dir_rows[i].rep, dir_rows[i].kind, dir_rows[i].ev);

    // random phases, each at its own register setting
    for (p = 0; p < PHASES; p++) begin
      wait_drained(SETTLE_CYCLES);
      case (p)
        0: begin thr = 8'd0;   dz = 15'd0;     end
        1: begin thr = 8'd255; dz = 15'd32767; end
        3: begin thr = 8'd0;   dz = 15'd32767; end
        4: begin thr = 8'd255; dz = 15'd0;     end
        default: begin thr = $urandom_range(1, 254); dz = $urandom_range(1, 32766); end
      endcase
      apply_setting(thr, dz);
      sink_calm = (p == 4);
      if (p == 3) begin
        // move the packet numbers into the upper half of the range
        r = gen_report();
        r.packet_number = 32'h8000_0000 + $urandom_range(0, 32'hFFFF);
        send_report(r, EXP_MODEL, '0);
      end
      if (p == 2) begin
        // long receiver hold-off while reports keep coming
        hold_requests++;
        src_calm = 1'b1;
        for (i = 0; i < 12; i++) begin
          r = gen_report();
          r.packet_number = seen_packet + 32'd1;
          send_report(r, EXP_MODEL, '0);
        end
        src_calm = 1'b0;
      end
      accepted = 0;
      while (accepted < PHASE_REPORTS) begin
        r = gen_report();
        if (r.packet_number > seen_packet) accepted++;
        send_report(r, EXP_MODEL, '0);
      end
    end

    // last part: no idling, top packet number, then only stale reports
    wait_drained(SETTLE_CYCLES);
    quiet = 1'b1;
    for (i = 0; i < 20; i++) begin
      r = gen_report();
      send_report(r, EXP_MODEL, '0);
    end
    r = gen_report();
    r.packet_number = 32'hFFFF_FFFF;
    send_report(r, EXP_MODEL, '0);
    for (i = 0; i < 3; i++) begin
      r = {$urandom(), $urandom(), $urandom(), $urandom()};
      send_report(r, EXP_MODEL, '0);
    end

    wait_drained(END_CYCLES);
    $display("run covered %0d reports (%0d stale) and %0d checked change events",
             reports_sent, stale_sent, changes_checked);
    $display("over %0d register settings besides reset, with one long receiver hold-off",
             settings_used);
    if (errors == 0) begin
      $display("tb_gamepad_change_event_generator passed");
    end else begin
      $display("tb_gamepad_change_event_generator failed");
    end
    $finish;
  end

endmodule

// ----- gamepad_change_event_generator.f -----
hw/rtl/gcev_pkg.sv
hw/rtl/gcev_ifs.sv
hw/rtl/gcev_cfg_regs.sv
hw/rtl/gcev_detect.sv
hw/rtl/gcev_emit.sv
hw/rtl/gamepad_change_event_generator.sv
hw/rtl/gcev_checker.sv
tb/tb_gamepad_change_event_generator.sv
